[sv/chm_pkg.sv]
// Package with the shared widths, codes and controller/datapath interface types.
package chm_pkg;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned STS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic             clr;
    logic             accept;
    logic             bkt_take;
    logic             ins_alloc;
    logic             ins_link;
    logic             walk_start;
    logic             walk_step;
    logic             rem_unlink;
    logic             res_set;
    logic [STS_W-1:0] res_status;
    logic             res_hit;
    logic             out_load;
  } chm_cmd_t;

  typedef struct packed {
    logic             clr_last;
    logic             mod_done;
    logic             head_null;
    logic             tail_null;
    logic             pool_empty;
    logic             key_match;
    logic             next_null;
    logic [CMD_W-1:0] cmd;
  } chm_sts_t;

endpackage

[sv/chained_hash_map_engine.sv]
// Top level of the chained hash map engine: controller and datapath.
// The input channel carries one command item (insert, find or remove) with a key
// and a value; the output channel returns one result item per command with a
// status and, for a successful find, the stored value.
// An item is accepted when in_valid_i is high and in_stall_o is low, and a result
// is taken when out_valid_o is high and out_stall_i is low.
// The engine works on one item at a time. An insert takes the bucket index, reads
// the bucket, allocates a node and, when the chain was not empty, links it to the
// old tail; a find or remove walks the chain node by node, set by the one-read-
// per-cycle node memories. Bucket counts other than a power of two pick the
// bucket by a reciprocal multiplication instead of a mask.
// After reset the bucket table is swept to empty, one bucket per cycle, and the
// input stalls until the sweep ends; the node pool starts with every node free.
// A finished result sits in the output register; the next item is accepted while
// it waits, and that item's result is held back until the receiver takes the
// earlier one.
module chained_hash_map_engine #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned POOL_NODES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [chm_pkg::CMD_W-1:0] in_cmd_i,
  input  logic [chm_pkg::KEY_W-1:0] in_key_i,
  input  logic [chm_pkg::VAL_W-1:0] in_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [chm_pkg::STS_W-1:0] out_status_o,
  output logic [chm_pkg::VAL_W-1:0] out_found_value_o
);
  import chm_pkg::*;

  chm_cmd_t cmd;
  chm_sts_t sts;

  chm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  chm_dp #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_cmd_i          (in_cmd_i),
    .in_key_i          (in_key_i),
    .in_value_i        (in_value_i),
    .out_status_o      (out_status_o),
    .out_found_value_o (out_found_value_o)
  );

endmodule

[sv/chm_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/chm_mod.sv]
// Bucket index unit: key modulo the bucket count, a mask, a reciprocal multiplication or zero for one bucket.
module chm_mod #(
  parameter int unsigned BUCKETS = 256
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [chm_pkg::KEY_W-1:0]                  key_i,
  output logic                                       done_o,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem_o
);
  import chm_pkg::*;

  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  if (BUCKETS == 1) begin : g_one
    assign done_o = start_i | 1'b1;
    assign rem_o  = (key_i == '0) ? 1'b0 : 1'b0;
  end else if (IS_POW2) begin : g_mask
    logic [BKT_W-1:0] rem_q;
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= key_i[BKT_W-1:0];
      end
    end
    assign done_o = 1'b1;
    assign rem_o  = rem_q;
  end else begin : g_recip
    // The quotient is the high part of the key times a rounded-up reciprocal,
    // exact for every 32-bit key; the remainder needs only its low bits.
    localparam int unsigned MW = KEY_W + 1;
    localparam int unsigned PW = KEY_W + MW;
    localparam int unsigned SH = KEY_W + BKT_W;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) / 64'(BUCKETS)) + 64'd1);

    logic [1:0]         stg_q;
    logic [KEY_W-1:0]   key_q;
    logic [PW-1:0]      prod_q;
    logic [BKT_W-1:0]   rem_q;
    logic [2*BKT_W-1:0] qd;

    assign qd = {{BKT_W{1'b0}}, prod_q[SH +: BKT_W]} * {{BKT_W{1'b0}}, BKT_W'(BUCKETS)};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q <= '0;
      end else if (start_i) begin
        stg_q <= 2'b01;
      end else begin
        stg_q <= {stg_q[0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
      end
      if (stg_q[0]) begin
        prod_q <= {{MW{1'b0}}, key_q} * {{KEY_W{1'b0}}, RECIP};
      end
      if (stg_q[1]) begin
        rem_q <= key_q[BKT_W-1:0] - qd[BKT_W-1:0];
      end
    end

    assign done_o = ~(|stg_q);
    assign rem_o  = rem_q;
  end

endmodule

[sv/chm_dp.sv]
// Datapath: bucket table, node pool memories, free stack, registers and output register.
module chm_dp #(
  parameter int unsigned BUCKETS    = 256,
  parameter int unsigned POOL_NODES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  chm_pkg::chm_cmd_t         cmd_i,
  output chm_pkg::chm_sts_t         sts_o,
  input  logic [chm_pkg::CMD_W-1:0] in_cmd_i,
  input  logic [chm_pkg::KEY_W-1:0] in_key_i,
  input  logic [chm_pkg::VAL_W-1:0] in_value_i,
  output logic [chm_pkg::STS_W-1:0] out_status_o,
  output logic [chm_pkg::VAL_W-1:0] out_found_value_o
);
  import chm_pkg::*;

  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned IDX_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned PTR_W = $clog2(POOL_NODES + 1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);
  localparam int unsigned KD_W = KEY_W + VAL_W;

  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;
  logic [BKT_W-1:0] bkt_q, clr_q, bkt_rem;
  logic [PTR_W-1:0] head_q, tail_q, cnt_q, cnt_d, lo_q, lo_d, cnt_m1;
  logic [IDX_W-1:0] cur_q, new_q, fs_initv_q, alloc_n, fs_raddr, node_raddr;
  logic             fs_init_q, mod_done;
  logic [STS_W-1:0] res_status_q, out_status_q;
  logic [VAL_W-1:0] res_fv_q, out_fv_q;

  logic [2*PTR_W-1:0] bkt_rd, bkt_wd;
  logic [BKT_W-1:0]   bkt_wa;
  logic               bkt_we;
  logic [PTR_W-1:0]   head_rd, tail_rd, nxt_rd, prv_rd;
  logic [KD_W-1:0]    kd_rd;
  logic [IDX_W-1:0]   fs_rd;
  logic               nxt_we, prv_we;
  logic [IDX_W-1:0]   nxt_wa, prv_wa;
  logic [PTR_W-1:0]   nxt_wd, prv_wd;

  chm_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.accept),
    .key_i   (in_key_i),
    .done_o  (mod_done),
    .rem_o   (bkt_rem)
  );

  assign head_rd = bkt_rd[2*PTR_W-1:PTR_W];
  assign tail_rd = bkt_rd[PTR_W-1:0];
  assign alloc_n = fs_init_q ? fs_initv_q : fs_rd;
  assign cnt_m1  = cnt_q - PTR_W'(1);
  assign fs_raddr = cnt_m1[IDX_W-1:0];
  assign node_raddr = cmd_i.walk_start ? head_rd[IDX_W-1:0] : nxt_rd[IDX_W-1:0];

  always_comb begin
    bkt_we = cmd_i.clr | cmd_i.ins_alloc | cmd_i.rem_unlink;
    bkt_wa = cmd_i.clr ? clr_q : bkt_q;
    if (cmd_i.clr) begin
      bkt_wd = {NIL, NIL};
    end else if (cmd_i.ins_alloc) begin
      bkt_wd = {(tail_rd >= NIL) ? PTR_W'(alloc_n) : head_rd, PTR_W'(alloc_n)};
    end else begin
      bkt_wd = {(head_q == PTR_W'(cur_q)) ? nxt_rd : head_q,
                (tail_q == PTR_W'(cur_q)) ? prv_rd : tail_q};
    end
  end

  always_comb begin
    nxt_we = cmd_i.ins_alloc | cmd_i.ins_link | (cmd_i.rem_unlink & (prv_rd < NIL));
    if (cmd_i.ins_alloc) begin
      nxt_wa = alloc_n;
      nxt_wd = NIL;
    end else if (cmd_i.ins_link) begin
      nxt_wa = tail_q[IDX_W-1:0];
      nxt_wd = PTR_W'(new_q);
    end else begin
      nxt_wa = prv_rd[IDX_W-1:0];
      nxt_wd = nxt_rd;
    end
    prv_we = cmd_i.ins_alloc | (cmd_i.rem_unlink & (nxt_rd < NIL));
    if (cmd_i.ins_alloc) begin
      prv_wa = alloc_n;
      prv_wd = tail_rd;
    end else begin
      prv_wa = nxt_rd[IDX_W-1:0];
      prv_wd = prv_rd;
    end
  end

  chm_ram #(.WIDTH(2*PTR_W), .DEPTH(BUCKETS)) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (bkt_wa),
    .wdata_i (bkt_wd),
    .raddr_i (bkt_rem),
    .rdata_o (bkt_rd)
  );

  chm_ram #(.WIDTH(KD_W), .DEPTH(POOL_NODES)) u_kd_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_alloc),
    .waddr_i (alloc_n),
    .wdata_i ({key_q, value_q}),
    .raddr_i (node_raddr),
    .rdata_o (kd_rd)
  );

  chm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_wa),
    .wdata_i (nxt_wd),
    .raddr_i (node_raddr),
    .rdata_o (nxt_rd)
  );

  chm_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_wa),
    .wdata_i (prv_wd),
    .raddr_i (node_raddr),
    .rdata_o (prv_rd)
  );

  chm_ram #(.WIDTH(IDX_W), .DEPTH(POOL_NODES)) u_fs_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rem_unlink),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (cur_q),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rd)
  );

  always_comb begin
    cnt_d = cnt_q;
    lo_d  = lo_q;
    if (cmd_i.ins_alloc) begin
      cnt_d = cnt_m1;
      if (cnt_m1 < lo_q) begin
        lo_d = cnt_m1;
      end
    end else if (cmd_i.rem_unlink) begin
      cnt_d = cnt_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      cnt_q <= NIL;
      lo_q  <= NIL;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      cnt_q <= cnt_d;
      lo_q  <= lo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fs_init_q  <= (cnt_m1 < lo_q);
    fs_initv_q <= IDX_W'(POOL_NODES - 1) - fs_raddr;
    if (cmd_i.accept) begin
      cmd_q   <= in_cmd_i;
      key_q   <= in_key_i;
      value_q <= in_value_i;
    end
    if (cmd_i.bkt_take) begin
      bkt_q <= bkt_rem;
    end
    if (cmd_i.ins_alloc | cmd_i.walk_start) begin
      head_q <= head_rd;
      tail_q <= tail_rd;
    end
    if (cmd_i.ins_alloc) begin
      new_q <= alloc_n;
    end
    if (cmd_i.walk_start | cmd_i.walk_step) begin
      cur_q <= node_raddr;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_fv_q     <= cmd_i.res_hit ? kd_rd[VAL_W-1:0] : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_fv_q     <= res_fv_q;
    end
  end

  always_comb begin
    sts_o.clr_last   = (clr_q == BKT_W'(BUCKETS - 1));
    sts_o.mod_done   = mod_done;
    sts_o.head_null  = (head_rd >= NIL);
    sts_o.tail_null  = (tail_rd >= NIL);
    sts_o.pool_empty = (cnt_q == '0);
    sts_o.key_match  = (kd_rd[KD_W-1:VAL_W] == key_q);
    sts_o.next_null  = (nxt_rd >= NIL);
    sts_o.cmd        = cmd_q;
  end

  assign out_status_o      = out_status_q;
  assign out_found_value_o = out_fv_q;

endmodule

[sv/chm_ctrl.sv]
// Controller state machine sequencing the bucket clear, insert, chain walk and result.
module chm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  chm_pkg::chm_sts_t sts_i,
  output chm_pkg::chm_cmd_t cmd_o
);
  import chm_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RDB  = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.bkt_take = 1'b1;
          state_d        = S_RDB;
        end
      end
      S_RDB: begin
        case (sts_i.cmd)
          CMD_INSERT: begin
            cmd_o.res_set = 1'b1;
            if (sts_i.pool_empty) begin
              cmd_o.res_status = ST_FULL;
              state_d          = S_FIN;
            end else begin
              cmd_o.ins_alloc  = 1'b1;
              cmd_o.res_status = ST_OK;
              state_d          = sts_i.tail_null ? S_FIN : S_LINK;
            end
          end
          CMD_FIND, CMD_REMOVE: begin
            if (sts_i.head_null) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_MISS;
              state_d          = S_FIN;
            end else begin
              cmd_o.walk_start = 1'b1;
              state_d          = S_WALK;
            end
          end
          default: begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_MISS;
            state_d          = S_FIN;
          end
        endcase
      end
      S_LINK: begin
        cmd_o.ins_link = 1'b1;
        state_d        = S_FIN;
      end
      S_WALK: begin
        if (sts_i.key_match) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_OK;
          if (sts_i.cmd == CMD_FIND) begin
            cmd_o.res_hit = 1'b1;
          end else begin
            cmd_o.rem_unlink = 1'b1;
          end
          state_d = S_FIN;
        end else if (sts_i.next_null) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_MISS;
          state_d          = S_FIN;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[dv/testbench.sv]
// Self-checking testbench for chained_hash_map_engine: directed table, random traffic, hold-off.
`timescale 1ns / 100ps

module testbench;
  import chm_pkg::*;

  localparam int unsigned BUCKET_CNT = 256;
  localparam int unsigned NODE_CNT = 1024;
  localparam logic [10:0] NULL_LINK = 11'd1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

  typedef struct {
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] value;
  } map_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               typed;
    logic [STS_W-1:0] status;
    logic [VAL_W-1:0] found;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [CMD_W-1:0] in_cmd_i;
  logic [KEY_W-1:0] in_key_i;
  logic [VAL_W-1:0] in_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [STS_W-1:0] out_status_o;
  logic [VAL_W-1:0] out_found_value_o;

  logic [10:0]      head_q [BUCKET_CNT];
  logic [10:0]      tail_q [BUCKET_CNT];
  logic [KEY_W-1:0] node_key_q [NODE_CNT];
  logic [VAL_W-1:0] node_val_q [NODE_CNT];
  logic [10:0]      node_next_q [NODE_CNT];
  logic [10:0]      node_prev_q [NODE_CNT];
  logic [9:0]       free_stk [NODE_CNT];
  int unsigned      free_cnt;
  logic [KEY_W-1:0] live_keys [$];

  map_result_t      pending_q [$];
  map_result_t      oldest;
  stim_row_t        dir_rows [$];
  int unsigned      errors = 0;
  int unsigned      results_seen = 0;
  int unsigned      cycle_cnt = 0;
  bit               quiet = 1'b0;
  bit               pressure_done = 1'b0;

  chained_hash_map_engine DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_cmd_i         (in_cmd_i),
    .in_key_i         (in_key_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_status_o     (out_status_o),
    .out_found_value_o(out_found_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [10:0] chain_lookup(logic [7:0] bkt, logic [KEY_W-1:0] key);
    logic [10:0] n;
    int unsigned steps;
    n = head_q[bkt];
    steps = 0;
    while (n < NULL_LINK && steps < NODE_CNT) begin
      if (node_key_q[n[9:0]] == key) return n;
      n = node_next_q[n[9:0]];
      steps++;
    end
    return NULL_LINK;
  endfunction

  function automatic map_result_t map_apply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] value);
    map_result_t res;
    logic [7:0]  bkt;
    logic [10:0] n;
    logic [10:0] nx;
    logic [10:0] pv;
    logic [10:0] t;
    bkt = key[7:0];
    res.status = ST_MISS;
    res.value = '0;
    case (cmd)
      CMD_INSERT: begin
        if (free_cnt == 0) begin
          res.status = ST_FULL;
        end else begin
          free_cnt--;
          n = {1'b0, free_stk[free_cnt]};
          t = tail_q[bkt];
          node_key_q[n[9:0]] = key;
          node_val_q[n[9:0]] = value;
          node_next_q[n[9:0]] = NULL_LINK;
          node_prev_q[n[9:0]] = t;
          if (t < NULL_LINK) node_next_q[t[9:0]] = n;
          else head_q[bkt] = n;
          tail_q[bkt] = n;
          live_keys.push_back(key);
          res.status = ST_OK;
        end
      end
      CMD_FIND: begin
        n = chain_lookup(bkt, key);
        if (n < NULL_LINK) begin
          res.status = ST_OK;
          res.value = node_val_q[n[9:0]];
        end
      end
      CMD_REMOVE: begin
        n = chain_lookup(bkt, key);
        if (n < NULL_LINK) begin
          nx = node_next_q[n[9:0]];
          pv = node_prev_q[n[9:0]];
          if (nx < NULL_LINK) node_prev_q[nx[9:0]] = pv;
          if (pv < NULL_LINK) node_next_q[pv[9:0]] = nx;
          if (head_q[bkt] == n) head_q[bkt] = nx;
          if (tail_q[bkt] == n) tail_q[bkt] = pv;
          if (free_cnt < NODE_CNT) begin
            free_stk[free_cnt] = n[9:0];
            free_cnt++;
          end
          foreach (live_keys[i]) begin
            if (live_keys[i] == key) begin
              live_keys.delete(i);
              break;
            end
          end
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(int unsigned w_ins, int unsigned w_find,
                                                int unsigned w_rem);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return CMD_INSERT;
    if (r < w_ins + w_find) return CMD_FIND;
    if (r < w_ins + w_find + w_rem) return CMD_REMOVE;
    return CMD_UNUSED;
  endfunction

  // Most keys land in sixteen crowded buckets so that chains grow long.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] key;
    logic [3:0]       hb;
    if (live_keys.size() > 0 && $urandom_range(0, 99) < 60)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    key = $urandom();
    hb = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 85) key[7:0] = {hb, hb ^ 4'h9};
    return key;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return ALL_ONES;
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_item(stim_row_t row);
    map_result_t res;
    while (!quiet && $urandom_range(0, 99) < 33) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_cmd_i   <= row.cmd;
    in_key_i   <= row.key;
    in_value_i <= row.value;
    do @(posedge clk_i); while (in_stall_o);
    res = map_apply(row.cmd, row.key, row.value);
    if (row.typed) begin
      res.status = row.status;
      res.value = row.found;
    end
    pending_q.push_back(res);
  endtask

  task automatic send_random(int unsigned w_ins, int unsigned w_find, int unsigned w_rem);
    stim_row_t row;
    row.cmd = pick_cmd(w_ins, w_find, w_rem);
    row.key = pick_key();
    row.value = pick_value();
    row.typed = 1'b0;
    row.status = ST_OK;
    row.found = '0;
    send_item(row);
  endtask

  task automatic add_row(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                         bit typed, logic [STS_W-1:0] status, logic [VAL_W-1:0] found);
    stim_row_t row;
    row.cmd = cmd;
    row.key = key;
    row.value = value;
    row.typed = typed;
    row.status = status;
    row.found = found;
    dir_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d value %h", $time, out_status_o,
                 out_found_value_o);
        errors++;
      end else begin
        oldest = pending_q.pop_front();
        if (out_status_o !== oldest.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, oldest.status,
                   out_status_o);
          errors++;
        end
        if (out_found_value_o !== oldest.value) begin
          $display("%0t: found_value mismatch, expected %h, actual %h", $time, oldest.value,
                   out_found_value_o);
          errors++;
        end
      end
    end
  end

  // The long hold-off lets the engine fill up and stall its input.
  initial begin : receiver
    int unsigned hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else if (!pressure_done && results_seen >= 60) begin
        pressure_done = 1'b1;
        hold = 300;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 33);
      end
    end
  end

  initial begin : stimulus
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_cmd_i   = CMD_INSERT;
    in_key_i   = '0;
    in_value_i = '0;
    for (int i = 0; i < BUCKET_CNT; i++) begin
      head_q[i] = NULL_LINK;
      tail_q[i] = NULL_LINK;
    end
    for (int i = 0; i < NODE_CNT; i++) free_stk[i] = 10'(NODE_CNT - 1 - i);
    free_cnt = NODE_CNT;

    add_row(CMD_FIND,   32'h0000_0000, ALL_ONES, 1, ST_MISS, '0);
    add_row(CMD_REMOVE, 32'hFFFF_FFFF, '0,       1, ST_MISS, '0);
    add_row(CMD_UNUSED, 32'h0000_0000, ALL_ONES, 1, ST_MISS, '0);
    add_row(CMD_INSERT, 32'h0000_0000, ALL_ONES, 1, ST_OK,   '0);
    add_row(CMD_FIND,   32'h0000_0000, '0,       1, ST_OK,   ALL_ONES);
    add_row(CMD_INSERT, 32'h0000_0100, '0,       1, ST_OK,   '0);
    add_row(CMD_INSERT, 32'h0000_0000, 64'h1,    1, ST_OK,   '0);
    add_row(CMD_FIND,   32'h0000_0000, '0,       1, ST_OK,   ALL_ONES);
    add_row(CMD_FIND,   32'h0000_0100, ALL_ONES, 1, ST_OK,   '0);
    add_row(CMD_REMOVE, 32'h0000_0000, '0,       1, ST_OK,   '0);
    add_row(CMD_FIND,   32'h0000_0000, '0,       0, ST_OK,   '0);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 1, ST_OK, '0);
    add_row(CMD_FIND,   32'hFFFF_FFFF, '0,       0, ST_OK,   '0);
    add_row(CMD_FIND,   32'h0000_00FF, '0,       1, ST_MISS, '0);
    add_row(CMD_REMOVE, 32'h0000_0100, '0,       1, ST_OK,   '0);
    add_row(CMD_REMOVE, 32'h0000_0100, '0,       1, ST_MISS, '0);
    add_row(CMD_UNUSED, 32'hFFFF_FFFF, ALL_ONES, 1, ST_MISS, '0);
    add_row(CMD_INSERT, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 0, ST_OK, '0);
    add_row(CMD_FIND,   32'hA5A5_A5A5, '0,       0, ST_OK,   '0);
    add_row(CMD_REMOVE, 32'hFFFF_FFFF, '0,       1, ST_OK,   '0);
    add_row(CMD_FIND,   32'hFFFF_FFFF, '0,       1, ST_MISS, '0);
    add_row(CMD_REMOVE, 32'h0000_0000, '0,       1, ST_OK,   '0);
    add_row(CMD_FIND,   32'h0000_0000, '0,       1, ST_MISS, '0);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    for (int i = 0; i < 200; i++) begin
      quiet = (i >= 60 && i < 140);
      send_random(40, 30, 25);
    end
    quiet = 1'b0;

    // Insert-heavy traffic grows the chains in the crowded buckets.
    for (int i = 0; i < 100; i++) send_random(88, 6, 4);

    for (int i = 0; i < 230; i++) send_random(8, 32, 55);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
